// File: src/rfez_pkg.sv
// Shared constants and helpers for the ZYX Euler rotation matrix block.
`default_nettype none
package rfez_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_LEN = 24;
    localparam int ANGLE_W = 16;
    localparam int ENTRY_W = 16;
    localparam int FOLD_W = 14;   // folded angle, |a| <= 5760
    localparam int CW = 34;       // CORDIC datapath width, Q30 plus headroom
    localparam int TRIG_W = 18;   // Q16 sine/cosine
    localparam int DEG_TO_RAD_Q30 = 292818;
    localparam int CORDIC_GAIN_Q30 = 652032874;
    localparam int ONE_Q14 = 16384;

    function automatic logic signed [CW-1:0] atan_q30(input int i);
        logic signed [CW-1:0] r;
        begin
            case (i)
                0: r = 34'sd843314856;
                1: r = 34'sd497837829;
                2: r = 34'sd263043836;
                3: r = 34'sd133525158;
                4: r = 34'sd67021686;
                5: r = 34'sd33543515;
                6: r = 34'sd16775850;
                7: r = 34'sd8388437;
                8: r = 34'sd4194282;
                9: r = 34'sd2097149;
                10: r = 34'sd1048575;
                11: r = 34'sd524287;
                12: r = 34'sd262143;
                13: r = 34'sd131071;
                14: r = 34'sd65535;
                15: r = 34'sd32767;
                16: r = 34'sd16383;
                17: r = 34'sd8191;
                18: r = 34'sd4095;
                19: r = 34'sd2047;
                20: r = 34'sd1023;
                21: r = 34'sd511;
                22: r = 34'sd255;
                23: r = 34'sd127;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

// File: src/rfez_sincos.sv
// Pipelined angle fold, degree-to-radian scale and CORDIC: one stage per step.
`default_nettype none
module rfez_sincos
    import rfez_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire                       aclk,
    input  wire                       en,
    input  wire logic signed [ANGLE_W-1:0] angle,
    output logic signed [TRIG_W-1:0]  sin_q16,
    output logic signed [TRIG_W-1:0]  cos_q16
);
    localparam int NSTEP = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;

    logic signed [FOLD_W-1:0] fold_next, fold_reg;
    logic                     flip_next, flip_reg;
    logic signed [CW-1:0]     z0_reg;
    logic                     flip0_reg;
    logic signed [CW-1:0]     x_reg [NSTEP+1];
    logic signed [CW-1:0]     y_reg [NSTEP+1];
    logic signed [CW-1:0]     z_reg [NSTEP+1];
    logic                     f_reg [NSTEP+1];
    logic signed [CW-1:0]     xo, yo;

    always_comb begin
        logic signed [ANGLE_W:0] a;
        a = {angle[ANGLE_W-1], angle};
        if (a > 23040) a = 17'sd23040;
        if (a < -23040) a = -17'sd23040;
        if (a > 11520) a = a - 17'sd23040;
        if (a < -11520) a = a + 17'sd23040;
        flip_next = 1'b0;
        if (a > 5760) begin
            a = a - 17'sd11520;
            flip_next = 1'b1;
        end else if (a < -5760) begin
            a = a + 17'sd11520;
            flip_next = 1'b1;
        end
        fold_next = FOLD_W'(a);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fold_reg  <= fold_next;
            flip_reg  <= flip_next;
            z0_reg    <= CW'(fold_reg) * CW'(DEG_TO_RAD_Q30);
            flip0_reg <= flip_reg;
        end
    end

    always_comb begin
        x_reg[0] = CW'(CORDIC_GAIN_Q30);
        y_reg[0] = '0;
        z_reg[0] = z0_reg;
        f_reg[0] = flip0_reg;
    end

    for (genvar i = 0; i < NSTEP; i++) begin : g_step
        always_ff @(posedge aclk) begin
            if (en) begin
                f_reg[i+1] <= f_reg[i];
                if (!z_reg[i][CW-1]) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_q30(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_q30(i);
                end
            end
        end
    end

    always_comb begin
        xo = f_reg[NSTEP] ? -x_reg[NSTEP] : x_reg[NSTEP];
        yo = f_reg[NSTEP] ? -y_reg[NSTEP] : y_reg[NSTEP];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cos_q16 <= TRIG_W'((xo + CW'(8192)) >>> 14);
            sin_q16 <= TRIG_W'((yo + CW'(8192)) >>> 14);
        end
    end
endmodule
`default_nettype wire

// File: src/rfez_matrix.sv
// Matrix products of the three sine/cosine pairs, rounding and clamp to Q2.14.
`default_nettype none
module rfez_matrix
    import rfez_pkg::*;
(
    input  wire                      aclk,
    input  wire                      en,
    input  wire logic signed [TRIG_W-1:0] sz, cz, sy, cy, sx, cx,
    output logic [9*ENTRY_W-1:0]     entries
);
    localparam int P2 = 2*TRIG_W;   // Q32 two-factor product
    localparam int P3 = 3*TRIG_W;   // Q48

    logic signed [P2-1:0] czcy_reg, szcy_reg, czsy_reg, szsy_reg;
    logic signed [P2-1:0] szcx_reg, szsx_reg, czcx_reg, czsx_reg;
    logic signed [P2-1:0] cysx_reg, cycx_reg;
    logic signed [TRIG_W-1:0] sx_reg, cx_reg, sy_reg;
    logic signed [P3-1:0] e_reg [9];

    function automatic logic [ENTRY_W-1:0] to_q14(input logic signed [P3-1:0] v);
        logic signed [P3-1:0] r;
        begin
            r = (v + (P3'(1) <<< 33)) >>> 34;
            if (r > P3'(ONE_Q14)) r = P3'(ONE_Q14);
            if (r < -P3'(ONE_Q14)) r = -P3'(ONE_Q14);
            return ENTRY_W'(r);
        end
    endfunction

    always_ff @(posedge aclk) begin
        if (en) begin
            czcy_reg <= P2'(cz) * P2'(cy);
            szcy_reg <= P2'(sz) * P2'(cy);
            czsy_reg <= P2'(cz) * P2'(sy);
            szsy_reg <= P2'(sz) * P2'(sy);
            szcx_reg <= P2'(sz) * P2'(cx);
            szsx_reg <= P2'(sz) * P2'(sx);
            czcx_reg <= P2'(cz) * P2'(cx);
            czsx_reg <= P2'(cz) * P2'(sx);
            cysx_reg <= P2'(cy) * P2'(sx);
            cycx_reg <= P2'(cy) * P2'(cx);
            sx_reg   <= sx;
            cx_reg   <= cx;
            sy_reg   <= sy;
            e_reg[0] <= P3'(czcy_reg) <<< 16;
            e_reg[1] <= P3'(czsy_reg) * P3'(sx_reg) - (P3'(szcx_reg) <<< 16);
            e_reg[2] <= P3'(czsy_reg) * P3'(cx_reg) + (P3'(szsx_reg) <<< 16);
            e_reg[3] <= P3'(szcy_reg) <<< 16;
            e_reg[4] <= P3'(szsy_reg) * P3'(sx_reg) + (P3'(czcx_reg) <<< 16);
            e_reg[5] <= P3'(szsy_reg) * P3'(cx_reg) - (P3'(czsx_reg) <<< 16);
            e_reg[6] <= -(P3'(sy_reg) <<< 32);
            e_reg[7] <= P3'(cysx_reg) <<< 16;
            e_reg[8] <= P3'(cycx_reg) <<< 16;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 9; k++) begin
                entries[k*ENTRY_W +: ENTRY_W] <= to_q14(e_reg[k]);
            end
        end
    end
endmodule
`default_nettype wire

// File: src/rotation_from_euler_zyx_top.sv
// Top level: ZYX Euler angles to rotation matrix, fully pipelined.
//
//  channel | ports          | beat contents
//  input   | s_axis_t*      | angle_z, angle_y, angle_x (16 b each, Q10.6 degrees)
//  result  | m_axis_t*      | m00..m22 (16 b each, Q2.14)
//
// One beat per cycle sustained while the output is not stalled; the pipeline is made of
// the CORDIC stage chain plus fold, scale, product and rounding stages.
// The whole pipeline advances when the output register is empty or taken;
// a stall freezes every stage. aresetn clears only the valid bits.
`default_nettype none
module rotation_from_euler_zyx_top
    import rfez_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [47:0] s_axis_tdata,   // angle_z, angle_y, angle_x
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [143:0] m_axis_tdata   // m00,m01,m02,m10,m11,m12,m20,m21,m22
);
    localparam int NSTEP = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
    // fold, scale, NSTEP CORDIC steps, trig rounding, products, sums, clamp
    localparam int LAT = NSTEP + 6;

    logic en;
    logic [LAT-1:0] vld_reg;
    logic signed [TRIG_W-1:0] sz, cz, sy, cy, sx, cx;

    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_axis_tvalid};
        end
    end

    rfez_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_z (
        .aclk(aclk), .en(en), .angle(s_axis_tdata[15:0]), .sin_q16(sz), .cos_q16(cz));
    rfez_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_y (
        .aclk(aclk), .en(en), .angle(s_axis_tdata[31:16]), .sin_q16(sy), .cos_q16(cy));
    rfez_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_x (
        .aclk(aclk), .en(en), .angle(s_axis_tdata[47:32]), .sin_q16(sx), .cos_q16(cx));

    rfez_matrix u_mat (
        .aclk(aclk), .en(en),
        .sz(sz), .cz(cz), .sy(sy), .cy(cy), .sx(sx), .cx(cx),
        .entries(m_axis_tdata));
endmodule
`default_nettype wire

// File: tb/tb.sv
// Testbench for the ZYX Euler rotation matrix block: fixed-point predictor, random stalls.
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import rfez_pkg::*;

    localparam int STEPS = CORDIC_STEPS_DEF;
    localparam int LATENCY = ((STEPS < ATAN_LEN) ? STEPS : ATAN_LEN) + 7;
    localparam int ANGLE_MAX = 23040;

    typedef struct packed {
        logic signed [15:0] m22, m21, m20, m12, m11, m10, m02, m01, m00;
    } matrix_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic [47:0] s_axis_tdata = '0;
    logic m_axis_tready = 1'b0;
    logic s_axis_tready;
    logic m_axis_tvalid;
    logic [143:0] m_axis_tdata;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int error_count = 0;
    matrix_t expected_matrices[$];

    rotation_from_euler_zyx_top u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("tb failed");
        $finish;
    end

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    // Q10.6 degrees in, Q16 sine and cosine out
    function automatic void trig_q16(longint a, output longint s, output longint c);
        bit flip;
        longint x, y, z, xn;
        flip = 1'b0;
        if (a > 23040) a = 23040;
        if (a < -23040) a = -23040;
        if (a > 11520) a -= 23040;
        if (a < -11520) a += 23040;
        if (a > 5760) begin
            a -= 11520;
            flip = 1'b1;
        end else if (a < -5760) begin
            a += 11520;
            flip = 1'b1;
        end
        x = CORDIC_GAIN_Q30;
        y = 0;
        z = a * DEG_TO_RAD_Q30;
        for (int i = 0; i < STEPS && i < ATAN_LEN; i++) begin
            if (z >= 0) begin
                xn = x - floor_shr(y, i);
                y = y + floor_shr(x, i);
                z -= longint'(atan_q30(i));
            end else begin
                xn = x + floor_shr(y, i);
                y = y - floor_shr(x, i);
                z += longint'(atan_q30(i));
            end
            x = xn;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = floor_shr(x + 8192, 14);
        s = floor_shr(y + 8192, 14);
    endfunction

    function automatic logic signed [15:0] round_q14(longint v);
        longint r;
        r = floor_shr(v + (longint'(1) << 33), 34);
        if (r > ONE_Q14) r = ONE_Q14;
        if (r < -ONE_Q14) r = -ONE_Q14;
        return r[15:0];
    endfunction

    function automatic matrix_t rotation_zyx(logic signed [15:0] az, logic signed [15:0] ay,
                                             logic signed [15:0] ax);
        longint sz, cz, sy, cy, sx, cx;
        longint k;
        matrix_t m;
        k = 65536;
        trig_q16(az, sz, cz);
        trig_q16(ay, sy, cy);
        trig_q16(ax, sx, cx);
        m.m00 = round_q14(cz * cy * k);
        m.m01 = round_q14(cz * sy * sx - sz * cx * k);
        m.m02 = round_q14(cz * sy * cx + sz * sx * k);
        m.m10 = round_q14(sz * cy * k);
        m.m11 = round_q14(sz * sy * sx + cz * cx * k);
        m.m12 = round_q14(sz * sy * cx - cz * sx * k);
        m.m20 = round_q14(-sy * k * k);
        m.m21 = round_q14(cy * sx * k);
        m.m22 = round_q14(cy * cx * k);
        return m;
    endfunction

    // send one angle set; expectation is queued at acceptance
    task automatic send_angles(logic [15:0] az, logic [15:0] ay, logic [15:0] ax);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {ax, ay, az};
        do @(posedge aclk); while (!s_axis_tready);
        expected_matrices.push_back(rotation_zyx(az, ay, ax));
    endtask

    task automatic go_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain();
        while (expected_matrices.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [15:0] rand_angle();
        case ($urandom_range(9))
            0: return 16'($urandom);   // anything, including beyond +-360
            1: return 16'($urandom_range(2 * ANGLE_MAX) - ANGLE_MAX);
            2: return 16'(($urandom_range(16) - 8) * 2880 + $urandom_range(4) - 2);
            default: return 16'($urandom_range(2 * ANGLE_MAX) - ANGLE_MAX);
        endcase
    endfunction

    task automatic test_directed();
        logic [15:0] corners[$];
        corners = '{16'sd0, 16'sd23040, -16'sd23040, 16'sd5760, -16'sd5760, 16'sd5761,
                    -16'sd5761, 16'sd11520, -16'sd11520, 16'sd11521, -16'sd11521,
                    16'h7FFF, 16'h8000, 16'sd23041, -16'sd23041, 16'sd1};
        foreach (corners[i]) send_angles(corners[i], corners[(i + 5) % 16],
                                         corners[(i + 11) % 16]);
        send_angles(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_angles(16'h5555, 16'hAAAA, 16'h5555);
        send_angles(16'hAAAA, 16'h5555, 16'hAAAA);
        go_idle();
    endtask

    task automatic test_random(int count, int idle_pct, int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_angles(rand_angle(), rand_angle(), rand_angle());
        go_idle();
    endtask

    task automatic test_pause_drain();
        send_idle_pct = 0;
        recv_stall_pct = 30;
        repeat (10) send_angles(rand_angle(), rand_angle(), rand_angle());
        go_idle();
        drain();
        repeat (10) send_angles(rand_angle(), rand_angle(), rand_angle());
        go_idle();
    endtask

    // result checker
    always @(posedge aclk) begin
        matrix_t got, want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (expected_matrices.size() == 0) begin
                $error("result beat with no expectation: %h", m_axis_tdata);
                error_count++;
            end else begin
                want = expected_matrices.pop_front();
                if (got.m00 !== want.m00) begin $error("m00 exp %0d got %0d", want.m00, got.m00); error_count++; end
                if (got.m01 !== want.m01) begin $error("m01 exp %0d got %0d", want.m01, got.m01); error_count++; end
                if (got.m02 !== want.m02) begin $error("m02 exp %0d got %0d", want.m02, got.m02); error_count++; end
                if (got.m10 !== want.m10) begin $error("m10 exp %0d got %0d", want.m10, got.m10); error_count++; end
                if (got.m11 !== want.m11) begin $error("m11 exp %0d got %0d", want.m11, got.m11); error_count++; end
                if (got.m12 !== want.m12) begin $error("m12 exp %0d got %0d", want.m12, got.m12); error_count++; end
                if (got.m20 !== want.m20) begin $error("m20 exp %0d got %0d", want.m20, got.m20); error_count++; end
                if (got.m21 !== want.m21) begin $error("m21 exp %0d got %0d", want.m21, got.m21); error_count++; end
                if (got.m22 !== want.m22) begin $error("m22 exp %0d got %0d", want.m22, got.m22); error_count++; end
            end
        end
    end

    // receiver ready
    always @(posedge aclk) begin
        if (!aresetn) m_axis_tready <= 1'b0;
        else m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(120, 0, 0);
        test_random(100, 71, 0);
        test_random(100, 0, 71);
        test_random(100, 12, 12);
        test_pause_drain();
        drain();
        repeat (LATENCY + 10) @(posedge aclk);
        if (error_count == 0 && expected_matrices.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

// File: files.f
src/rfez_pkg.sv
src/rfez_sincos.sv
src/rfez_matrix.sv
src/rotation_from_euler_zyx_top.sv
tb/tb.sv
